>>> hw/rtl/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// shared types and constants for the median-of-set unit
// ----------------------------------------------------------------------------
package mos_pkg;

    localparam int MAX_SAMPLES  = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int COUNT_W      = $clog2(MAX_SAMPLES + 1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           has_sample;
        logic                           last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] median_value;
        logic [COUNT_W-1:0]             sample_count;
        logic                           overflowed;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SH_RD,
        S_SH_CMP,
        S_PLACE,
        S_CLOSE,
        S_LO,
        S_HI
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_shift;
        logic shift_step;
        logic place;
        logic mark_ovf;
        logic rd_lo;
        logic rd_hi;
        logic cap_lo;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic               has_sample;
        logic               last;
        logic               full;
        logic               pos_zero;
        logic               pos_one;
        logic               gt;
        logic               count_zero;
        logic               count_odd;
        logic               ovf;
        logic [COUNT_W-1:0] count;
    } t_sts;

endpackage

>>> hw/rtl/mos_ctrl.sv
// ----------------------------------------------------------------------------
// mos_ctrl
// sequencer for insertion, overflow marking and median readout
// ----------------------------------------------------------------------------
module mos_ctrl
    import mos_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_sts.last ? S_CLOSE : S_IDLE;
                if (i_sts.has_sample) begin
                    if (i_sts.full) begin
                        o_cmd.mark_ovf = 1'b1;
                    end else if (i_sts.pos_zero) begin
                        o_cmd.place = 1'b1;
                    end else begin
                        o_cmd.rd_shift = 1'b1;
                        n_state        = S_SH_CMP;
                    end
                end
            end
            S_SH_RD: begin
                o_cmd.rd_shift = 1'b1;
                n_state        = S_SH_CMP;
            end
            S_SH_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.shift_step = 1'b1;
                    n_state          = i_sts.pos_one ? S_PLACE : S_SH_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = i_sts.last ? S_CLOSE : S_IDLE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = i_sts.last ? S_CLOSE : S_IDLE;
            end
            S_CLOSE: begin
                if (i_sts.count_zero) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_sts.count_odd) begin
                    o_cmd.rd_hi = 1'b1;
                    n_state     = S_HI;
                end else begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_LO;
                end
            end
            S_LO: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_hi  = 1'b1;
                n_state      = S_HI;
            end
            S_HI: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hw/rtl/mos_dpath.sv
// ----------------------------------------------------------------------------
// mos_dpath
// sorted sample store, insertion pointer, count and median arithmetic
// ----------------------------------------------------------------------------
module mos_dpath
    import mos_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_result,
    output logic      o_result_valid
);

    logic signed [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_has;
    logic                           r_last;
    logic [ADDR_W-1:0]              r_pos;
    logic [COUNT_W-1:0]             r_count;
    logic                           r_ovf;
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;
    logic signed [SAMPLE_WIDTH-1:0] r_lo;
    t_out_item                      r_result;
    logic                           r_valid;

    logic [ADDR_W-1:0]              rd_addr;
    logic                           rd_en;
    logic [ADDR_W-1:0]              half_n;
    logic signed [SAMPLE_WIDTH:0]   sum;
    logic signed [SAMPLE_WIDTH:0]   sum_adj;
    logic signed [SAMPLE_WIDTH-1:0] median;

    assign half_n = r_count[COUNT_W-1:1];
    assign rd_en  = i_cmd.rd_shift | i_cmd.rd_lo | i_cmd.rd_hi;

    always_comb begin
        if (i_cmd.rd_shift) begin
            rd_addr = r_pos - ADDR_W'(1);
        end else if (i_cmd.rd_lo) begin
            rd_addr = half_n - ADDR_W'(1);
        end else begin
            rd_addr = half_n;
        end
    end

    // store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_step) begin
            mem[r_pos] <= r_rdata;
        end else if (i_cmd.place) begin
            mem[r_pos] <= r_x;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // (lo + hi) / 2 rounded toward zero, one guard bit for the sum
    assign sum     = {r_lo[SAMPLE_WIDTH-1], r_lo} + {r_rdata[SAMPLE_WIDTH-1], r_rdata};
    assign sum_adj = sum + (SAMPLE_WIDTH+1)'(sum[SAMPLE_WIDTH] & sum[0]);

    always_comb begin
        if (r_count == '0) begin
            median = '0;
        end else if (r_count[0]) begin
            median = r_rdata;
        end else begin
            median = sum_adj[SAMPLE_WIDTH:1];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_item.sample;
            r_has  <= i_item.has_sample;
            r_last <= i_item.last;
            r_pos  <= r_count[ADDR_W-1:0];
        end else if (i_cmd.shift_step) begin
            r_pos  <= r_pos - ADDR_W'(1);
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_result.median_value <= median;
            r_result.sample_count <= r_count;
            r_result.overflowed   <= r_ovf;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (i_cmd.place) begin
                    r_count <= r_count + COUNT_W'(1);
                end
                if (i_cmd.mark_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_sts.has_sample = r_has;
    assign o_sts.last       = r_last;
    assign o_sts.full       = (r_count == COUNT_W'(MAX_SAMPLES));
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.pos_one    = (r_pos == ADDR_W'(1));
    assign o_sts.gt         = (r_rdata > r_x);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_odd  = r_count[0];
    assign o_sts.ovf        = r_ovf;
    assign o_sts.count      = r_count;

    assign o_result       = r_result;
    assign o_result_valid = r_valid;

endmodule

>>> hw/rtl/median_of_set_unit.sv
// ----------------------------------------------------------------------------
// median_of_set_unit
// median of a set of signed samples kept in a sorted store
// ----------------------------------------------------------------------------
// per item: one without sample is only loaded; on an empty store the sample is placed,
//   on a full one it is dropped and the overflow flag set, else each larger kept entry is
//   read and shifted up first; a new item is taken only back in idle; a last item then reads
//   the middle entry or entries if any; the strobe rises in the cycle after the emit
// reset: synchronous active low; clears count, overflow flag and sequencer, not the store
// the result strobe is one cycle wide and cannot be held off by the receiver
module median_of_set_unit
    import mos_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_result_valid
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: accepts an item when idle, walks the insertion shift,
    // then reads the one or two middle entries on the last item of a non-empty set
    mos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: sorted store, insertion pointer, count, overflow flag,
    // and the half-sum for even counts
    mos_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // a result comes only from an emit in the previous cycle
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(cmd.emit))
        else $error("result strobe without emit");

    // the set restarts together with the result
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (sts.count_zero && !sts.ovf && !busy))
        else $error("store not restarted after result");

    // the count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.count <= COUNT_W'(MAX_SAMPLES))
        else $error("kept count beyond capacity");

endmodule

>>> tb/sv/tb_median_of_set_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_of_set_unit
// self-checking bench for the median-of-set unit: a directed table of corner
// sets, then random sets of mixed length and content, every result checked
// field by field against the table or an in-bench sorted-insertion predictor
// ----------------------------------------------------------------------------
module tb_median_of_set_unit
    import mos_pkg::*;
();

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 700;
    // watchdog limit, sized from about 800 items each at the cost of the worst insert and readout
    localparam int CYCLE_LIMIT  = 600000;
    // longest insert plus readout, with margin
    localparam int DRAIN_CYCLES = 2 * MAX_SAMPLES + 16;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // one row of the directed table; want is used only where typed is set
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    t_out_item o_result;
    logic      o_result_valid;

    median_of_set_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // predictor state: the kept samples in ascending order, their count and
    // the flag for samples dropped on a full store
    logic signed [SAMPLE_WIDTH-1:0] ordered_samples [MAX_SAMPLES];
    int                             kept_n       = 0;
    bit                             dropped_flag = 1'b0;

    // medians still to come from the unit, oldest first
    t_out_item median_expect_q[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int fed_items     = 0;
    bit quiet_stretch = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    // one accepted item through the predictor; returns 1 when it closes a set
    function automatic bit median_step(input t_in_item it, output t_out_item res);
        int                             pos;
        longint                         pair_sum;
        logic signed [SAMPLE_WIDTH-1:0] med;
        res = '0;
        med = '0;
        if (it.has_sample) begin
            if (kept_n >= MAX_SAMPLES) begin
                // store full: sample is lost, flag sticks until the set closes
                dropped_flag = 1'b1;
            end else begin
                // insertion sort step; equal samples stay ahead of the new one
                pos = kept_n;
                while (pos > 0 && ordered_samples[pos-1] > $signed(it.sample)) begin
                    ordered_samples[pos] = ordered_samples[pos-1];
                    pos--;
                end
                ordered_samples[pos] = it.sample;
                kept_n++;
            end
        end
        if (!it.last) begin
            return 1'b0;
        end
        if (kept_n != 0) begin
            if (kept_n % 2 == 0) begin
                // mean of the two middle samples in 64 bits, truncated toward zero
                pair_sum = longint'(ordered_samples[kept_n/2 - 1])
                         + longint'(ordered_samples[kept_n/2]);
                med = SAMPLE_WIDTH'(pair_sum / 2);
            end else begin
                med = ordered_samples[kept_n/2];
            end
        end
        res.median_value = med;
        res.sample_count = COUNT_W'(kept_n);
        res.overflowed   = dropped_flag;
        kept_n       = 0;
        dropped_flag = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_row stim_row(
        input logic signed [SAMPLE_WIDTH-1:0] smp,
        input bit                             has,
        input bit                             lst,
        input bit                             typed = 1'b0,
        input logic signed [SAMPLE_WIDTH-1:0] w_med = '0,
        input int                             w_cnt = 0,
        input bit                             w_ovf = 1'b0
    );
        t_row r;
        r.item.sample            = smp;
        r.item.has_sample        = has;
        r.item.last              = lst;
        r.typed                  = typed;
        r.want.median_value      = w_med;
        r.want.sample_count      = COUNT_W'(w_cnt);
        r.want.overflowed        = w_ovf;
        return r;
    endfunction

    // sample mix: full-range words, a narrow band around zero for duplicates,
    // and values hugging both ends of the range
    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 9)) inside
            [0:4]:   return SAMPLE_WIDTH'($urandom);
            [5:6]:   return SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
            7:       return SAMPLE_MAX - SAMPLE_WIDTH'($urandom_range(0, 3));
            8:       return SAMPLE_MIN + SAMPLE_WIDTH'($urandom_range(0, 3));
            default: return '0;
        endcase
    endfunction

    // present one item and hold it until the unit takes it; ahead of it, start
    // stays low in about a fifth of the cycles where the unit could take one
    task automatic add_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item predicted;
        if (!quiet_stretch) begin
            while ($urandom_range(0, 99) < 22) begin
                start <= 1'b0;
                do @(posedge i_clk); while (busy);
            end
        end
        start  <= 1'b1;
        i_item <= it;
        // busy is sampled before this edge's updates, so !busy here means taken
        do @(posedge i_clk); while (busy);
        if (median_step(it, predicted)) begin
            if (typed) begin
                predicted = want;
            end
            median_expect_q = {median_expect_q, predicted};
        end
        fed_items++;
    endtask

    // result checker: the strobe lasts one cycle and cannot be stalled
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (median_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result median %0d count %0d ovf %0b",
                                o_result.median_value, o_result.sample_count,
                                o_result.overflowed));
            end else begin
                want = median_expect_q.pop_front();
                if (o_result.median_value !== want.median_value) begin
                    report_mismatch($sformatf("median_value got %0d want %0d",
                                    o_result.median_value, want.median_value));
                end
                if (o_result.sample_count !== want.sample_count) begin
                    report_mismatch($sformatf("sample_count got %0d want %0d",
                                    o_result.sample_count, want.sample_count));
                end
                if (o_result.overflowed !== want.overflowed) begin
                    report_mismatch($sformatf("overflowed got %0b want %0b",
                                    o_result.overflowed, want.overflowed));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_row     directed_rows[$];
        t_in_item it;
        int       set_idx;
        int       set_len;
        int       roll;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sets: empty set, ignored item, single extremes, extreme
        // pairs (the min/max pair halves to zero), an odd negative half,
        // equal samples, sets closed by an item with no sample
        directed_rows = '{
            stim_row('0, 1'b0, 1'b1, 1'b1, '0, 0, 1'b0),
            stim_row(12345, 1'b0, 1'b0),
            stim_row(SAMPLE_MAX, 1'b1, 1'b1, 1'b1, SAMPLE_MAX, 1, 1'b0),
            stim_row(SAMPLE_MIN, 1'b1, 1'b1, 1'b1, SAMPLE_MIN, 1, 1'b0),
            stim_row(SAMPLE_MAX, 1'b1, 1'b0),
            stim_row(SAMPLE_MAX, 1'b1, 1'b1, 1'b1, SAMPLE_MAX, 2, 1'b0),
            stim_row(SAMPLE_MIN, 1'b1, 1'b0),
            stim_row(SAMPLE_MIN, 1'b1, 1'b1, 1'b1, SAMPLE_MIN, 2, 1'b0),
            stim_row(SAMPLE_MIN, 1'b1, 1'b0),
            stim_row(SAMPLE_MAX, 1'b1, 1'b1, 1'b1, '0, 2, 1'b0),
            stim_row(-3, 1'b1, 1'b0),
            stim_row(0, 1'b1, 1'b1, 1'b1, -1, 2, 1'b0),
            stim_row(5, 1'b1, 1'b0),
            stim_row(-7, 1'b1, 1'b0),
            stim_row(5, 1'b1, 1'b0),
            stim_row(5, 1'b1, 1'b1),
            stim_row(7, 1'b1, 1'b0),
            stim_row(3, 1'b1, 1'b0),
            stim_row(-9, 1'b0, 1'b1),
            stim_row(-1, 1'b1, 1'b0),
            stim_row(-2, 1'b1, 1'b0),
            stim_row(SAMPLE_MAX - 1, 1'b1, 1'b1)
        };
        foreach (directed_rows[r]) begin
            add_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        // random sets; the first overruns the store so the dropped-sample path is always hit, the
        // second fills it unless its closing item lacks a sample, the rest are mostly short
        fed_items = 0;
        set_idx   = 0;
        while (fed_items < RANDOM_ITEMS) begin
            if (set_idx == 0) begin
                set_len = MAX_SAMPLES + 2;
            end else if (set_idx == 1) begin
                set_len = MAX_SAMPLES;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    set_len = $urandom_range(1, 9);
                end else if (roll < 90) begin
                    set_len = $urandom_range(10, 40);
                end else begin
                    set_len = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 8);
                end
            end
            for (int k = 0; k < set_len; k++) begin
                // an item carrying nothing inside a set must leave it alone
                if ($urandom_range(0, 9) == 0) begin
                    it.sample     = rand_sample();
                    it.has_sample = 1'b0;
                    it.last       = 1'b0;
                    add_item(it, 1'b0, '0);
                end
                // a stretch of the run with no idle gaps at all
                quiet_stretch = (fed_items >= 250 && fed_items < 400);
                it.sample     = rand_sample();
                it.has_sample = 1'b1;
                it.last       = (k == set_len - 1);
                // some sets close on an item without a sample
                if (it.last && $urandom_range(0, 4) == 0) begin
                    it.has_sample = 1'b0;
                end
                add_item(it, 1'b0, '0);
            end
            set_idx++;
        end
        start <= 1'b0;

        // wait out every pending median, then the longest insert and readout
        while (median_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
